// ===== sv/pba_pkg.sv =====
// Shared types and constants for the primitive bounds accumulator.
// No dependencies; every other file imports this package.
package pba_pkg;

  localparam int unsigned NUM_AXES   = 3;
  localparam int unsigned SPAN_W     = 16;
  localparam int unsigned AREA_W     = 52;
  // products carry 32 fraction bits; doubling and dropping 16 of them is >> 15
  localparam int unsigned AREA_SHIFT = 15;
  localparam int unsigned MIN_RADIUS = 655;  // 0.01 in Q16.16

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_BOUNDS_MODE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SPAN    = 4'd1;

  localparam logic [SPAN_W-1:0] MIN_SPAN_RESET = 16'd66;

  // Per-cycle control shared by the three axis lanes. Fields with a stage suffix are named
  // after the pipeline register stage they are read from.
  typedef struct packed {
    logic              en;
    logic              mode;
    logic              func_s1;
    logic              func_s4;
    logic              upd_s5;
    logic              last_s5;
    logic [SPAN_W-1:0] min_span;
  } pba_lane_ctl_t;

endpackage

// ===== sv/pba_if.sv =====
// Valid/ready channel interfaces: primitive input, box result, config write.
// Depends on pba_pkg.
interface pba_in_if #(
  parameter int unsigned COORD_WIDTH = 32
) ();
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic signed [COORD_WIDTH-1:0] ax;
  logic signed [COORD_WIDTH-1:0] ay;
  logic signed [COORD_WIDTH-1:0] az;
  logic signed [COORD_WIDTH-1:0] bx;
  logic signed [COORD_WIDTH-1:0] by_coord;
  logic signed [COORD_WIDTH-1:0] bz;
  logic signed [COORD_WIDTH-1:0] cx;
  logic signed [COORD_WIDTH-1:0] cy;
  logic signed [COORD_WIDTH-1:0] cz;
  logic signed [COORD_WIDTH-1:0] sphere_radius;
  logic                          last_item;

  modport source (
    output valid, func, ax, ay, az, bx, by_coord, bz, cx, cy, cz, sphere_radius, last_item,
    input  ready
  );
  modport sink (
    input  valid, func, ax, ay, az, bx, by_coord, bz, cx, cy, cz, sphere_radius, last_item,
    output ready
  );
endinterface

interface pba_out_if import pba_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 32
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] box_min_x;
  logic signed [COORD_WIDTH-1:0] box_min_y;
  logic signed [COORD_WIDTH-1:0] box_min_z;
  logic signed [COORD_WIDTH-1:0] box_max_x;
  logic signed [COORD_WIDTH-1:0] box_max_y;
  logic signed [COORD_WIDTH-1:0] box_max_z;
  logic [AREA_W-1:0]             surface_area;
  logic                          box_valid;

  modport source (
    output valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
           surface_area, box_valid,
    input  ready
  );
  modport sink (
    input  valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
           surface_area, box_valid,
    output ready
  );
endinterface

interface pba_cfg_if import pba_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/pba_lane.sv =====
// One axis lane: primitive extent or centroid, running min/max union, final widening.
// Depends on pba_pkg.
module pba_lane import pba_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pba_lane_ctl_t                 ctl_i,
  input  logic signed [COORD_WIDTH-1:0] a_i,
  input  logic signed [COORD_WIDTH-1:0] b_i,
  input  logic signed [COORD_WIDTH-1:0] c_i,
  input  logic [COORD_WIDTH-2:0]        rad_i,  // clamped radius, stage 1 aligned
  output logic signed [COORD_WIDTH-1:0] box_min_o,
  output logic signed [COORD_WIDTH-1:0] box_max_o
);

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned SW = W + 2;       // sum of three coordinates
  localparam int unsigned MW = W + 1;       // |sum| + 1
  localparam int unsigned ML = MW / 2;
  localparam int unsigned MH = MW - ML;
  localparam logic [MW:0]   TWO_MW = {1'b1, {MW{1'b0}}};
  localparam logic [MW-1:0] RECIP  = MW'(TWO_MW / 3);
  localparam logic signed [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};

  function automatic logic signed [W-1:0] sat_w(input logic [W:0] x);
    logic signed [W-1:0] r;
    if (x[W] != x[W-1]) begin
      r = x[W] ? CMIN : CMAX;
    end else begin
      r = x[W-1:0];
    end
    return r;
  endfunction

  logic [W:0] span_x;
  assign span_x = {{(W+1-SPAN_W){1'b0}}, ctl_i.min_span};

  // stage 1: vertex extent and coordinate sum
  logic signed [W-1:0] lo1_d, hi1_d;
  logic [SW-1:0]       sum1_d;
  logic signed [W-1:0] a1_q, lo1_q, hi1_q;
  logic [SW-1:0]       sum1_q;

  always_comb begin
    lo1_d = a_i;
    hi1_d = a_i;
    if (b_i < lo1_d) lo1_d = b_i;
    if (c_i < lo1_d) lo1_d = c_i;
    if (b_i > hi1_d) hi1_d = b_i;
    if (c_i > hi1_d) hi1_d = c_i;
    sum1_d = {{2{a_i[W-1]}}, a_i} + {{2{b_i[W-1]}}, b_i} + {{2{c_i[W-1]}}, c_i};
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      a1_q   <= a_i;
      lo1_q  <= lo1_d;
      hi1_q  <= hi1_d;
      sum1_q <= sum1_d;
    end
  end

  // stage 2: primitive box (sphere or flat-widened triangle), centroid magnitude
  logic [SW-1:0]       abs2;
  logic [MW-1:0]       m2_d;
  logic signed [W-1:0] bmin2_d, bmax2_d;
  logic [W:0]          a_ext, r_ext;
  logic                neg2_q;
  logic [MW-1:0]       m2_q;
  logic signed [W-1:0] a2_q, bmin2_q, bmax2_q;

  always_comb begin
    abs2  = sum1_q[SW-1] ? (~sum1_q + 1'b1) : sum1_q;
    m2_d  = abs2[MW-1:0] + {{(MW-1){1'b0}}, 1'b1};
    a_ext = {a1_q[W-1], a1_q};
    r_ext = {2'b00, rad_i};
    if (ctl_i.func_s1) begin
      bmin2_d = sat_w(a_ext - r_ext);
      bmax2_d = sat_w(a_ext + r_ext);
    end else if (lo1_q == hi1_q) begin
      bmin2_d = sat_w({lo1_q[W-1], lo1_q} - span_x);
      bmax2_d = sat_w({hi1_q[W-1], hi1_q} + span_x);
    end else begin
      bmin2_d = lo1_q;
      bmax2_d = hi1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      neg2_q  <= sum1_q[SW-1];
      m2_q    <= m2_d;
      a2_q    <= a1_q;
      bmin2_q <= bmin2_d;
      bmax2_q <= bmax2_d;
    end
  end

  // stage 3: divide by three via reciprocal, two partial products
  logic [ML+MW-1:0]    pplo3_q;
  logic [MH+MW-1:0]    pphi3_q;
  logic                neg3_q;
  logic [MW-1:0]       m3_q;
  logic signed [W-1:0] a3_q, bmin3_q, bmax3_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      pplo3_q <= {{MW{1'b0}}, m2_q[ML-1:0]} * {{ML{1'b0}}, RECIP};
      pphi3_q <= {{MW{1'b0}}, m2_q[MW-1:ML]} * {{MH{1'b0}}, RECIP};
      neg3_q  <= neg2_q;
      m3_q    <= m2_q;
      a3_q    <= a2_q;
      bmin3_q <= bmin2_q;
      bmax3_q <= bmax2_q;
    end
  end

  // stage 4: merge partial products, quotient estimate (exact or one low)
  logic [2*MW-1:0]     prod4;
  logic [MW-1:0]       q0_4_q, m4_q;
  logic                neg4_q;
  logic signed [W-1:0] a4_q, bmin4_q, bmax4_q;

  assign prod4 = {pphi3_q, {ML{1'b0}}} + {{MH{1'b0}}, pplo3_q};

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      q0_4_q  <= prod4[2*MW-1:MW];
      m4_q    <= m3_q;
      neg4_q  <= neg3_q;
      a4_q    <= a3_q;
      bmin4_q <= bmin3_q;
      bmax4_q <= bmax3_q;
    end
  end

  // stage 5: quotient correction, sign, choose box or point
  logic [MW-1:0]       rem5, q5, nq5;
  logic signed [W-1:0] cent5, pt5, pmin5_d, pmax5_d;
  logic signed [W-1:0] pmin5_q, pmax5_q;

  always_comb begin
    rem5  = m4_q - {q0_4_q[MW-2:0], 1'b0} - q0_4_q;
    q5    = q0_4_q + {{(MW-1){1'b0}}, (rem5 >= MW'(3))};
    nq5   = ~q5 + 1'b1;
    cent5 = neg4_q ? nq5[W-1:0] : q5[W-1:0];
    pt5   = ctl_i.func_s4 ? a4_q : cent5;
    if (ctl_i.mode) begin
      pmin5_d = pt5;
      pmax5_d = pt5;
    end else begin
      pmin5_d = bmin4_q;
      pmax5_d = bmax4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      pmin5_q <= pmin5_d;
      pmax5_q <= pmax5_d;
    end
  end

  // stage 6: running union; a last item hands the box on and clears it
  logic signed [W-1:0] run_min_q, run_max_q, umin6, umax6;
  logic signed [W-1:0] fin_min_q, fin_max_q;

  assign umin6 = (pmin5_q < run_min_q) ? pmin5_q : run_min_q;
  assign umax6 = (pmax5_q > run_max_q) ? pmax5_q : run_max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_min_q <= CMAX;
      run_max_q <= CMIN;
    end else if (ctl_i.en && ctl_i.upd_s5) begin
      if (ctl_i.last_s5) begin
        run_min_q <= CMAX;
        run_max_q <= CMIN;
      end else begin
        run_min_q <= umin6;
        run_max_q <= umax6;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en && ctl_i.upd_s5 && ctl_i.last_s5) begin
      fin_min_q <= umin6;
      fin_max_q <= umax6;
    end
  end

  // stage 7: widen a flat axis of the final box
  logic signed [W-1:0] box_min_q, box_max_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      if (fin_min_q == fin_max_q) begin
        box_min_q <= sat_w({fin_min_q[W-1], fin_min_q} - span_x);
        box_max_q <= sat_w({fin_max_q[W-1], fin_max_q} + span_x);
      end else begin
        box_min_q <= fin_min_q;
        box_max_q <= fin_max_q;
      end
    end
  end

  assign box_min_o = box_min_q;
  assign box_max_o = box_max_q;

endmodule

// ===== sv/pba_area.sv =====
// Merge stage: validity of the three lane extents and box surface area.
// Depends on pba_pkg.
module pba_area import pba_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic signed [COORD_WIDTH-1:0] box_min_i [NUM_AXES],
  input  logic signed [COORD_WIDTH-1:0] box_max_i [NUM_AXES],
  output logic signed [COORD_WIDTH-1:0] box_min_o [NUM_AXES],
  output logic signed [COORD_WIDTH-1:0] box_max_o [NUM_AXES],
  output logic [AREA_W-1:0]             area_o,
  output logic                          box_valid_o
);

  localparam int unsigned W    = COORD_WIDTH;
  localparam int unsigned PW   = 2 * W;
  localparam int unsigned SUMW = PW + 2;
  localparam int unsigned EXTW = (SUMW > AREA_W + AREA_SHIFT + 1) ? SUMW
                                                                  : AREA_W + AREA_SHIFT + 1;

  // stage A: validity and per-axis spans
  logic                ok_d;
  logic [W-1:0]        span_d [NUM_AXES];
  logic                ok_a_q;
  logic [W-1:0]        span_a_q [NUM_AXES];
  logic signed [W-1:0] min_a_q [NUM_AXES], max_a_q [NUM_AXES];

  always_comb begin
    ok_d = 1'b1;
    for (int i = 0; i < NUM_AXES; i++) begin
      if (!(box_min_i[i] < box_max_i[i])) ok_d = 1'b0;
      span_d[i] = box_max_i[i] - box_min_i[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ok_a_q   <= ok_d;
      span_a_q <= span_d;
      min_a_q  <= box_min_i;
      max_a_q  <= box_max_i;
    end
  end

  // stage B: face products
  logic [PW-1:0]       pxy_q, pxz_q, pyz_q;
  logic                ok_b_q;
  logic signed [W-1:0] min_b_q [NUM_AXES], max_b_q [NUM_AXES];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pxy_q   <= {{W{1'b0}}, span_a_q[0]} * {{W{1'b0}}, span_a_q[1]};
      pxz_q   <= {{W{1'b0}}, span_a_q[0]} * {{W{1'b0}}, span_a_q[2]};
      pyz_q   <= {{W{1'b0}}, span_a_q[1]} * {{W{1'b0}}, span_a_q[2]};
      ok_b_q  <= ok_a_q;
      min_b_q <= min_a_q;
      max_b_q <= max_a_q;
    end
  end

  // stage C: sum of faces
  logic [SUMW-1:0]     sum_c_q;
  logic                ok_c_q;
  logic signed [W-1:0] min_c_q [NUM_AXES], max_c_q [NUM_AXES];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_c_q <= {2'b00, pxy_q} + {2'b00, pxz_q} + {2'b00, pyz_q};
      ok_c_q  <= ok_b_q;
      min_c_q <= min_b_q;
      max_c_q <= max_b_q;
    end
  end

  // scale to Q16.16 (x2, drop 16 fraction bits) and saturate; zero for an invalid box
  logic [EXTW-1:0] sum_ext, sum_sh;

  always_comb begin
    sum_ext = {{(EXTW-SUMW){1'b0}}, sum_c_q};
    sum_sh  = sum_ext >> AREA_SHIFT;
    if (!ok_c_q) begin
      area_o = '0;
    end else if (|sum_sh[EXTW-1:AREA_W]) begin
      area_o = '1;
    end else begin
      area_o = sum_sh[AREA_W-1:0];
    end
  end

  assign box_valid_o = ok_c_q;
  assign box_min_o   = min_c_q;
  assign box_max_o   = max_c_q;

endmodule

// ===== sv/primitive_bounds_accumulator.sv =====
// Bounding box union over a stream of triangles and spheres in signed Q16.16. One item
// is taken every clock cycle unless the pipeline holds; a result (box, surface area,
// valid flag) is made for each accepted last-marked item. Three axis lanes run side by
// side and the area merge is a three-stage multiply/add pipeline. The pipeline holds
// only while a result sits in its final stage and the output register is full and not
// taken. Configuration is taken every cycle (ready held high) and must be written
// while idle. Depends on pba_pkg, pba_if, pba_lane and pba_area.
module primitive_bounds_accumulator import pba_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pba_in_if.sink    in_i,
  pba_out_if.source res_o,
  pba_cfg_if.sink   cfg_i
);

  localparam int unsigned W     = COORD_WIDTH;
  localparam int unsigned DEPTH = 10;  // stages ahead of the output register
  localparam int unsigned S_UPD = 5;   // stage feeding the running union
  localparam logic [W-2:0] RAD_FLOOR = (W-1)'(MIN_RADIUS);

  // configuration registers
  logic              mode_q;
  logic [SPAN_W-1:0] min_span_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= 1'b0;
      min_span_q <= MIN_SPAN_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_BOUNDS_MODE: mode_q     <= cfg_i.data[0];
        REG_MIN_SPAN:    min_span_q <= cfg_i.data[SPAN_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic             en, res_valid_q;
  logic [DEPTH:1]   vld_q;
  logic [S_UPD:1]   last_q;
  logic [S_UPD-1:1] func_q;

  assign en         = !(vld_q[DEPTH] && res_valid_q && !res_o.ready);
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q[1] <= in_i.valid;
      for (int k = 2; k <= DEPTH; k++) begin
        if (k == S_UPD + 1) begin
          // past the union only items that carry a result move on
          vld_q[k] <= vld_q[S_UPD] && last_q[S_UPD];
        end else begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      last_q <= {last_q[S_UPD-1:1], in_i.last_item};
      func_q <= {func_q[S_UPD-2:1], in_i.func};
    end
  end

  // sphere radius: absolute value, saturate, raise to the floor
  logic [W-1:0] rad_mag;
  logic [W-2:0] rad_sat, rad_d, rad1_q;

  always_comb begin
    rad_mag = in_i.sphere_radius[W-1] ? (~in_i.sphere_radius + 1'b1) : in_i.sphere_radius;
    rad_sat = rad_mag[W-1] ? '1 : rad_mag[W-2:0];
    rad_d   = (rad_sat < RAD_FLOOR) ? RAD_FLOOR : rad_sat;
  end

  always_ff @(posedge clk_i) begin
    if (en) rad1_q <= rad_d;
  end

  // axis lanes
  pba_lane_ctl_t       lane_ctl;
  logic signed [W-1:0] a_ax [NUM_AXES], b_ax [NUM_AXES], c_ax [NUM_AXES];
  logic signed [W-1:0] lmin [NUM_AXES], lmax [NUM_AXES];

  assign lane_ctl.en       = en;
  assign lane_ctl.mode     = mode_q;
  assign lane_ctl.func_s1  = func_q[1];
  assign lane_ctl.func_s4  = func_q[S_UPD-1];
  assign lane_ctl.upd_s5   = vld_q[S_UPD];
  assign lane_ctl.last_s5  = last_q[S_UPD];
  assign lane_ctl.min_span = min_span_q;

  assign a_ax[0] = in_i.ax;
  assign a_ax[1] = in_i.ay;
  assign a_ax[2] = in_i.az;
  assign b_ax[0] = in_i.bx;
  assign b_ax[1] = in_i.by_coord;
  assign b_ax[2] = in_i.bz;
  assign c_ax[0] = in_i.cx;
  assign c_ax[1] = in_i.cy;
  assign c_ax[2] = in_i.cz;

  for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
    pba_lane #(
      .COORD_WIDTH(COORD_WIDTH)
    ) u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (lane_ctl),
      .a_i       (a_ax[g]),
      .b_i       (b_ax[g]),
      .c_i       (c_ax[g]),
      .rad_i     (rad1_q),
      .box_min_o (lmin[g]),
      .box_max_o (lmax[g])
    );
  end

  // merge: validity and area
  logic signed [W-1:0] mmin [NUM_AXES], mmax [NUM_AXES];
  logic [AREA_W-1:0]   area;
  logic                box_ok;

  pba_area #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_area (
    .clk_i       (clk_i),
    .en_i        (en),
    .box_min_i   (lmin),
    .box_max_i   (lmax),
    .box_min_o   (mmin),
    .box_max_o   (mmax),
    .area_o      (area),
    .box_valid_o (box_ok)
  );

  // output register
  logic signed [W-1:0] out_min_q [NUM_AXES], out_max_q [NUM_AXES];
  logic [AREA_W-1:0]   out_area_q;
  logic                out_ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (en && vld_q[DEPTH]) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && vld_q[DEPTH]) begin
      out_min_q  <= mmin;
      out_max_q  <= mmax;
      out_area_q <= area;
      out_ok_q   <= box_ok;
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.box_min_x    = out_min_q[0];
  assign res_o.box_min_y    = out_min_q[1];
  assign res_o.box_min_z    = out_min_q[2];
  assign res_o.box_max_x    = out_max_q[0];
  assign res_o.box_max_y    = out_max_q[1];
  assign res_o.box_max_z    = out_max_q[2];
  assign res_o.surface_area = out_area_q;
  assign res_o.box_valid    = out_ok_q;

endmodule
